@@ rtl/core/sdf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_pkg
// shared constants and types of the order-preserving deduplication filter
// ----------------------------------------------------------------------------
package sdf_pkg;

  // store depth: number of distinct values held per array
  localparam int MAX_DISTINCT = 64;

  localparam int IDX_W   = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
  localparam int CNT_W   = $clog2(MAX_DISTINCT + 1);

  // fixed field widths of the channels
  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 6;
  localparam int UCNT_W  = 7;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      end_of_array;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } back_state_t;

endpackage
`default_nettype wire

@@ rtl/core/sdf_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_in_if
// input channel: one array element per item with its end mark
// ----------------------------------------------------------------------------
interface sdf_in_if
  import sdf_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      end_of_array;

  modport source (output valid, output value, output end_of_array, input ready);
  modport sink   (input valid, input value, input end_of_array, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sdf_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_out_if
// result channel: keep/drop decision, slot and running unique count
// ----------------------------------------------------------------------------
interface sdf_out_if
  import sdf_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      kept;
  logic signed [VALUE_W-1:0] value_out;
  logic [SLOT_W-1:0]         slot;
  logic [UCNT_W-1:0]         unique_count;
  logic                      last;
  logic                      overflow;

  modport source (
    output valid, output kept, output value_out, output slot,
    output unique_count, output last, output overflow, input ready
  );
  modport sink (
    input valid, input kept, input value_out, input slot,
    input unique_count, input last, input overflow, output ready
  );
endinterface
`default_nettype wire

@@ rtl/core/stable_dedup_filter.sv @@
`default_nettype none
// the scan compares an accepted item against the values already stored for
//   the array, one stored value a cycle through the single store read port;
//   a repeat found early ends the scan sooner
// the engine takes the next item only once the result of the last one is
//   registered; the front queue holds items that arrive meanwhile
// reset: synchronous rst empties the queue and the result register and sets
//   the stored count to zero; stored values need no clearing
// ----------------------------------------------------------------------------
// stable_dedup_filter
// order-preserving deduplication of a stream of values, per array
// ----------------------------------------------------------------------------
module stable_dedup_filter
  import sdf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sdf_in_if.sink    in_ch,
  sdf_out_if.source out_ch
);

  // queue head handed from the front to the search engine
  item_t q_item;
  logic  q_valid;
  logic  q_take;

  // front: takes items in and holds them while the back is busy scanning
  sdf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_take  (q_take)
  );

  // back: compares against the stored values until a match, appends first
  // occurrences, clears the count after the item with the end mark and holds the result
  // in a register so that scanning of the next item can start meanwhile
  sdf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_take  (q_take),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

@@ rtl/core/sdf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_front
// accepts input items into a short queue that feeds the search engine
// ----------------------------------------------------------------------------
module sdf_front
  import sdf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  sdf_in_if.sink     in_ch,
  output item_t      q_item,
  output logic       q_valid,
  input  wire logic  q_take
);

  item_t             entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign in_ch.ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill != '0);
  assign pop         = q_valid && q_take;
  assign q_item      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= '{value: in_ch.value, end_of_array: in_ch.end_of_array};
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sdf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_back
// scans the value store one entry a cycle and issues the keep/drop result
// ----------------------------------------------------------------------------
module sdf_back
  import sdf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t q_item,
  input  wire logic  q_valid,
  output logic       q_take,
  sdf_out_if.source  out_ch
);

  back_state_t              state;
  back_state_t              state_next;

  logic signed [VALUE_W-1:0] store [MAX_DISTINCT];
  logic signed [VALUE_W-1:0] rd_data;

  item_t                    cur;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         ptr;
  logic                     pend;
  logic                     found;

  logic                     start;
  logic                     issue;
  logic                     hit;
  logic                     finish;
  logic                     match;
  logic                     full;
  logic                     new_ok;

  assign match  = pend && (rd_data == cur.value);
  assign full   = (count == CNT_W'(MAX_DISTINCT));
  assign new_ok = !found && !full;

  always_comb begin
    state_next = state;
    q_take     = 1'b0;
    start      = 1'b0;
    issue      = 1'b0;
    hit        = 1'b0;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_take     = 1'b1;
          start      = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          hit        = 1'b1;
          state_next = ST_RESULT;
        end else if (ptr == count) begin
          state_next = ST_RESULT;
        end else begin
          issue = 1'b1;
        end
      end
      ST_RESULT: begin
        if (!out_ch.valid || out_ch.ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      pend         <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (finish) begin
        if (cur.end_of_array) begin
          count <= '0;
        end else if (new_ok) begin
          count <= count + 1'b1;
        end
      end
      if (finish) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // working registers of the current item
  always_ff @(posedge clk) begin
    if (start) begin
      cur   <= q_item;
      ptr   <= '0;
      found <= 1'b0;
    end else begin
      if (issue) begin
        ptr <= ptr + 1'b1;
      end
      if (hit) begin
        found <= 1'b1;
      end
    end
  end

  // value store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (finish && new_ok) begin
      store[count[IDX_W-1:0]] <= cur.value;
    end
    if (issue) begin
      rd_data <= store[ptr[IDX_W-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (finish) begin
      out_ch.kept         <= new_ok;
      out_ch.value_out    <= cur.value;
      out_ch.slot         <= new_ok ? SLOT_W'(count[IDX_W-1:0]) : '0;
      out_ch.unique_count <= UCNT_W'(count + CNT_W'(new_ok));
      out_ch.last         <= cur.end_of_array;
      out_ch.overflow     <= !found && full;
    end
  end

endmodule
`default_nettype wire

@@ dv/dedup_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_checker
// watches both channels of the deduplication filter, predicts each result
// from its own copy of the distinct-value store and compares field by field
// ----------------------------------------------------------------------------
module dedup_checker
  import sdf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sdf_in_if         in_mon,
  sdf_out_if        out_mon,
  output int        mismatches,
  output int        outstanding
);

  typedef struct packed {
    logic              kept;
    logic [VALUE_W-1:0] value_out;
    logic [SLOT_W-1:0]  slot;
    logic [UCNT_W-1:0]  unique_count;
    logic              last;
    logic              overflow;
  } dedup_result_t;

  // distinct values of the current array, in arrival order
  logic [VALUE_W-1:0] distinct_vals [MAX_DISTINCT];
  int unsigned        distinct_n;

  dedup_result_t expected_results [$];

  assign outstanding = expected_results.size();

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("mismatch at %0t: %s got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic dedup_result_t dedup_step(input logic [VALUE_W-1:0] v,
                                               input logic eoa);
    dedup_result_t r;
    bit            hit;
    r   = '0;
    hit = 1'b0;
    for (int i = 0; i < int'(distinct_n); i++)
      if (distinct_vals[i] == v) hit = 1'b1;
    if (!hit) begin
      if (distinct_n < MAX_DISTINCT) begin
        distinct_vals[distinct_n] = v;
        r.slot = SLOT_W'(distinct_n);
        r.kept = 1'b1;
        distinct_n++;
      end else begin
        r.overflow = 1'b1;
      end
    end
    r.value_out    = v;
    r.unique_count = UCNT_W'(distinct_n);
    r.last         = eoa;
    if (eoa) distinct_n = 0;
    return r;
  endfunction

  always @(posedge clk) begin
    dedup_result_t got, want;
    if (rst) begin
      distinct_n = 0;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(dedup_step(in_mon.value, in_mon.end_of_array));
      if (out_mon.valid && out_mon.ready) begin
        got.kept         = out_mon.kept;
        got.value_out    = out_mon.value_out;
        got.slot         = out_mon.slot;
        got.unique_count = out_mon.unique_count;
        got.last         = out_mon.last;
        got.overflow     = out_mon.overflow;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, value_out", got.value_out, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.kept !== want.kept)
            report_mismatch("kept", VALUE_W'(got.kept), VALUE_W'(want.kept));
          if (got.value_out !== want.value_out)
            report_mismatch("value_out", got.value_out, want.value_out);
          if (got.slot !== want.slot)
            report_mismatch("slot", VALUE_W'(got.slot), VALUE_W'(want.slot));
          if (got.unique_count !== want.unique_count)
            report_mismatch("unique_count", VALUE_W'(got.unique_count),
                            VALUE_W'(want.unique_count));
          if (got.last !== want.last)
            report_mismatch("last", VALUE_W'(got.last), VALUE_W'(want.last));
          if (got.overflow !== want.overflow)
            report_mismatch("overflow", VALUE_W'(got.overflow), VALUE_W'(want.overflow));
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// drives arrays of signed values into the deduplication filter, with repeats,
// extremes, single-element arrays and arrays that fill the store to overflow;
// random idling on both channels, the checker beside the block gives the count
// ----------------------------------------------------------------------------
module tb;
  import sdf_pkg::*;

  logic clk;
  logic rst;

  sdf_in_if  in_ch ();
  sdf_out_if out_ch ();

  int mismatches;
  int outstanding;

  // random idling on both sides while set; cleared for quiet stretches
  bit idling;
  int items_sent;

  stable_dedup_filter dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  dedup_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #1000000;
    $display("** stable_dedup_filter: FAILED **");
    $finish;
  end

  // result side: ready drops in bursts while idling is on
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 11) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // offer one item and hold it until the handshake; an optional gap comes first
  task automatic push_element(input logic [VALUE_W-1:0] v, input logic eoa);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.value        <= v;
    in_ch.end_of_array <= eoa;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // stop sending until every outstanding result has come back
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic [VALUE_W-1:0] pool [6];
    logic [VALUE_W-1:0] arr_vals [$];
    logic [VALUE_W-1:0] v;
    int                 arr_len;
    int                 array_no;
    bit                 full_array;
    bit                 eoa;
    int                 waited;

    rst                <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.value        <= '0;
    in_ch.end_of_array <= 1'b0;
    idling             = 1'b1;
    items_sent         = 0;
    array_no           = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, repeats, end mark on a repeat and on a new value
    push_element(32'h0000_0000, 1'b0);
    push_element(32'hffff_ffff, 1'b0);
    push_element(32'h8000_0000, 1'b0);
    push_element(32'h7fff_ffff, 1'b0);
    push_element(32'h0000_0000, 1'b0);  // repeat of zero
    push_element(32'h8000_0000, 1'b0);  // repeat of the most negative value
    push_element(32'h0000_0001, 1'b0);
    push_element(32'hffff_fffe, 1'b0);
    push_element(32'hffff_ffff, 1'b1);  // end mark on a repeat
    // single-element array: store was cleared, so this is kept at slot zero
    push_element(32'h8000_0000, 1'b1);
    push_element(32'h7fff_ffff, 1'b0);
    push_element(32'h7fff_ffff, 1'b0);
    push_element(32'h7fff_fffe, 1'b1);  // end mark on a new value
    push_element(32'haaaa_aaaa, 1'b0);
    push_element(32'h5555_5555, 1'b0);
    push_element(32'haaaa_aaaa, 1'b1);
    hold_until_drained();

    // random arrays; every twelfth one fills the store and runs into overflow
    while (items_sent < 500) begin
      array_no++;
      full_array = (array_no % 12 == 4);
      if (items_sent >= 440) idling = 1'b0;
      else idling = ($urandom_range(0, 3) != 0);
      arr_vals.delete();
      if (full_array) begin
        arr_len = $urandom_range(MAX_DISTINCT + 2, MAX_DISTINCT + 10);
        for (int i = 0; i < arr_len; i++) begin
          // past the fill point, mix repeats (dropped) with new values (overflow)
          if (i >= MAX_DISTINCT + 2 && $urandom_range(0, 1) == 0)
            v = arr_vals[$urandom_range(0, arr_vals.size() - 1)];
          else
            v = $urandom();
          arr_vals.push_back(v);
          push_element(v, i == arr_len - 1);
        end
      end else begin
        // small pool per array so that repeats are common
        foreach (pool[k]) begin
          if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
              0: pool[k] = 32'h0000_0000;
              1: pool[k] = 32'hffff_ffff;
              2: pool[k] = 32'h8000_0000;
              default: pool[k] = 32'h7fff_ffff;
            endcase
          end else begin
            pool[k] = $urandom();
          end
        end
        arr_len = $urandom_range(1, 12);
        for (int i = 0; i < arr_len; i++) begin
          if ($urandom_range(0, 4) == 0) v = $urandom();  // noise
          else v = pool[$urandom_range(0, 5)];
          // now and then the end mark is missing and the array runs on
          eoa = (i == arr_len - 1) && ($urandom_range(0, 9) != 0);
          push_element(v, eoa);
        end
      end
      if (!idling && items_sent < 440) begin
        // nothing
      end else if ($urandom_range(0, 14) == 0) begin
        hold_until_drained();
      end
    end
    in_ch.valid <= 1'b0;
    idling = 1'b0;

    // drain the remaining results, then allow for a late stray one
    waited = 0;
    while (outstanding != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (outstanding != 0) begin
      $display("** stable_dedup_filter: FAILED **");
    end else begin
      repeat (80) @(posedge clk);
      if (mismatches == 0 && outstanding == 0) begin
        $display("** stable_dedup_filter: PASSED **");
      end else begin
        $display("** stable_dedup_filter: FAILED **");
      end
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/sdf_pkg.sv
rtl/core/sdf_in_if.sv
rtl/core/sdf_out_if.sv
rtl/core/sdf_front.sv
rtl/core/sdf_back.sv
rtl/core/stable_dedup_filter.sv
dv/dedup_checker.sv
dv/tb.sv
